FILE: sv/assert_macros.svh
// Assertion macros shared by the arithmetic unit's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// When the condition holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

FILE: sv/qalu_pkg.sv
// Types and constants shared by the fixed-point arithmetic unit.
`timescale 1ns / 1ps
package qalu_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned FQ_DEPTH = 2;
   localparam int unsigned FQ_AW    = $clog2(FQ_DEPTH);
   localparam int unsigned FQ_CW    = $clog2(FQ_DEPTH + 1);

   typedef enum logic [3:0] {
      OP_ADD   = 4'd0,
      OP_SUB   = 4'd1,
      OP_MUL   = 4'd2,
      OP_DIV   = 4'd3,
      OP_INC   = 4'd4,
      OP_DEC   = 4'd5,
      OP_TOINT = 4'd6,
      OP_MIN   = 4'd7,
      OP_MAX   = 4'd8
   } op_type;

   // Item after classification in the front part.
   typedef struct packed {
      logic [3:0]               op;
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
      logic                     lt;
      logic                     gt;
      logic                     eq;
      logic                     dbz;
   } item_type;

   // Partial result that travels alongside the divider.
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     lt;
      logic                     gt;
      logic                     eq;
      logic                     ovf;
      logic                     dbz;
      logic                     is_mul;
      logic                     is_div;
      logic                     q_neg;
   } side_type;

endpackage

FILE: sv/q24_8_fixed_point_alu_core.sv
// Top level of the signed fixed-point arithmetic unit.
// Usage: the request side behaves as a queue input. An item (opcode, operand A,
// operand B) is taken at a rising clock edge with req_push high and req_full low.
// The response side behaves as a queue output: while rsp_empty is low the oldest
// result sits on the rsp_ ports, and it is taken at an edge with rsp_pop high.
// Each item gives exactly one result, in order: a raw value plus less, greater,
// equal, overflow and divide-by-zero flags.
// The front part classifies items into a two-entry queue; the back part is a
// fixed pipeline whose length is set by the restoring divider, one quotient bit
// per stage, so 32 + FRAC_BITS stages. Every opcode passes through the queue,
// all of these stages and the result register before its result shows.
// Throughput is one item per cycle while results are popped every cycle.
// When the receiver stops popping, the back pipeline holds, the front queue
// fills up within two items and req_full rises; nothing is lost or reordered.
// Reset clears the queue and all valid flags; no result is pending afterwards.
`timescale 1ns / 1ps
module q24_8_fixed_point_alu_core #(
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [3:0]                         req_op,
   input  logic signed [qalu_pkg::DATA_W-1:0] req_operand_a,
   input  logic signed [qalu_pkg::DATA_W-1:0] req_operand_b,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic signed [qalu_pkg::DATA_W-1:0] rsp_result_value,
   output logic                               rsp_a_less,
   output logic                               rsp_a_greater,
   output logic                               rsp_a_equal,
   output logic                               rsp_overflow,
   output logic                               rsp_divide_by_zero
);
   import qalu_pkg::*;

   // Classified items waiting for the execution pipeline.
   item_type item;
   logic     item_valid;
   logic     item_pop;

   qalu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_op        (req_op),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop)
   );

   // The back part pulls an item whenever its pipeline can move.
   qalu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock              (clock),
      .reset              (reset),
      .item_valid         (item_valid),
      .item               (item),
      .item_pop           (item_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_result_value   (rsp_result_value),
      .rsp_a_less         (rsp_a_less),
      .rsp_a_greater      (rsp_a_greater),
      .rsp_a_equal        (rsp_a_equal),
      .rsp_overflow       (rsp_overflow),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

endmodule

FILE: sv/qalu_front.sv
// Front part: takes items, classifies them and holds them in a short queue.
`timescale 1ns / 1ps
module qalu_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [3:0]                       req_op,
   input  logic signed [qalu_pkg::DATA_W-1:0] req_operand_a,
   input  logic signed [qalu_pkg::DATA_W-1:0] req_operand_b,
   output logic                             item_valid,
   output qalu_pkg::item_type               item,
   input  logic                             item_pop
);
   import qalu_pkg::*;
   `include "assert_macros.svh"

   item_type             slot_ff [FQ_DEPTH];
   item_type             new_item;
   logic [FQ_AW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FQ_CW-1:0]     count_ff, count_in;
   logic                 push_ok, pop_ok;

   always_comb begin
      new_item.op  = req_op;
      new_item.a   = req_operand_a;
      new_item.b   = req_operand_b;
      new_item.lt  = req_operand_a < req_operand_b;
      new_item.gt  = req_operand_a > req_operand_b;
      new_item.eq  = req_operand_a == req_operand_b;
      new_item.dbz = (req_op == OP_DIV) && (req_operand_b == '0);
   end

   assign req_full   = count_ff == FQ_CW'(FQ_DEPTH);
   assign item_valid = count_ff != '0;
   assign item       = slot_ff[rd_ptr_ff];
   assign push_ok    = req_push && !req_full;
   assign pop_ok     = item_pop && item_valid;

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push_ok, pop_ok})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

   `ASSERT_ALWAYS(a_fq_bound, clock, reset, count_ff <= FQ_CW'(FQ_DEPTH), "queue count beyond depth")
   `ASSERT_NEXT(a_fq_full_hold, clock, reset, req_full && !item_pop, count_ff == $past(count_ff), "full queue changed without a pop")

endmodule

FILE: sv/qalu_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module qalu_div #(
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  advance,
   input  logic [qalu_pkg::DATA_W+FRAC_BITS-1:0] dividend,
   input  logic [qalu_pkg::DATA_W-1:0]           divisor,
   output logic [qalu_pkg::DATA_W+FRAC_BITS-1:0] quotient
);
   import qalu_pkg::*;

   localparam int unsigned NQ = DATA_W + FRAC_BITS;

   logic [DATA_W-1:0] rem_ff [NQ];
   logic [NQ-1:0]     num_ff [NQ];
   logic [DATA_W-1:0] den_ff [NQ];

   for (genvar i = 0; i < NQ; i++) begin : g_stage
      logic [DATA_W-1:0] rem_src, den_src, rem_in;
      logic [NQ-1:0]     num_src, num_in;
      logic [DATA_W:0]   trial, diff;

      if (i == 0) begin : g_first
         assign rem_src = '0;
         assign num_src = dividend;
         assign den_src = divisor;
      end else begin : g_next
         assign rem_src = rem_ff[i-1];
         assign num_src = num_ff[i-1];
         assign den_src = den_ff[i-1];
      end

      // Shift in the next dividend bit and try to subtract the divisor.
      assign trial  = {rem_src, num_src[NQ-1]};
      assign diff   = trial - {1'b0, den_src};
      assign rem_in = diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
      assign num_in = {num_src[NQ-2:0], !diff[DATA_W]};

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i] <= rem_in;
            num_ff[i] <= num_in;
            den_ff[i] <= den_src;
         end
      end
   end

   assign quotient = num_ff[NQ-1];

endmodule

FILE: sv/qalu_back.sv
// Back part: execution pipeline with the divider and the result register.
`timescale 1ns / 1ps
module qalu_back #(
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               item_valid,
   input  qalu_pkg::item_type                 item,
   output logic                               item_pop,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic signed [qalu_pkg::DATA_W-1:0] rsp_result_value,
   output logic                               rsp_a_less,
   output logic                               rsp_a_greater,
   output logic                               rsp_a_equal,
   output logic                               rsp_overflow,
   output logic                               rsp_divide_by_zero
);
   import qalu_pkg::*;
   `include "assert_macros.svh"

   localparam int unsigned NQ      = DATA_W + FRAC_BITS;
   localparam logic [63:0] ROUND64 = (64'd1 << FRAC_BITS) - 64'd1;
   localparam logic [DATA_W-1:0] ROUND32 = DATA_W'(ROUND64);

   logic                     adv;
   logic                     valid_ff [NQ];
   side_type                 side_ff  [NQ];
   side_type                 side_in, mul_fix, fin;
   logic signed [63:0]       prod_ff, prod_in, prod_adj;
   logic [DATA_W-1:0]        mag_a, mag_b;
   logic [NQ-1:0]            quotient;
   logic signed [DATA_W:0]   sum33;
   logic signed [DATA_W-1:0] rhs, toint_adj;
   logic                     out_valid_ff;
   side_type                 out_ff;

   // The whole pipeline moves together whenever the result register frees up.
   assign adv       = !out_valid_ff || rsp_pop;
   assign item_pop  = adv && item_valid;
   assign rsp_empty = !out_valid_ff;

   assign mag_a = item.a[DATA_W-1] ? (~item.a + 1'b1) : item.a;
   assign mag_b = item.b[DATA_W-1] ? (~item.b + 1'b1) : item.b;

   qalu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .advance  (adv),
      .dividend ({mag_a, FRAC_BITS'(0)}),
      .divisor  (mag_b),
      .quotient (quotient)
   );

   // Entry stage: add, subtract, increment, decrement, to-integer, min, max and the raw product.
   always_comb begin
      rhs = ((item.op == OP_INC) || (item.op == OP_DEC)) ? DATA_W'(1) : item.b;
      if ((item.op == OP_SUB) || (item.op == OP_DEC)) begin
         sum33 = {item.a[DATA_W-1], item.a} - {rhs[DATA_W-1], rhs};
      end else begin
         sum33 = {item.a[DATA_W-1], item.a} + {rhs[DATA_W-1], rhs};
      end
      toint_adj = item.a + (item.a[DATA_W-1] ? ROUND32 : '0);
      prod_in   = $signed(item.a) * $signed(item.b);

      side_in.lt     = item.lt;
      side_in.gt     = item.gt;
      side_in.eq     = item.eq;
      side_in.dbz    = item.dbz;
      side_in.is_mul = item.op == OP_MUL;
      side_in.is_div = item.op == OP_DIV;
      side_in.q_neg  = item.a[DATA_W-1] ^ item.b[DATA_W-1];
      side_in.value  = '0;
      side_in.ovf    = 1'b0;
      unique case (item.op)
         OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
            side_in.value = sum33[DATA_W-1:0];
            side_in.ovf   = sum33[DATA_W] ^ sum33[DATA_W-1];
         end
         OP_TOINT: side_in.value = toint_adj >>> FRAC_BITS;
         OP_MIN:   side_in.value = item.lt ? item.a : item.b;
         OP_MAX:   side_in.value = item.gt ? item.a : item.b;
         default:  side_in.value = '0;
      endcase
   end

   // Second stage: scale the product back, truncating toward zero.
   always_comb begin
      prod_adj = (prod_ff + (prod_ff[63] ? $signed(ROUND64) : 64'sd0)) >>> FRAC_BITS;
      mul_fix  = side_ff[0];
      if (side_ff[0].is_mul) begin
         mul_fix.value = prod_adj[DATA_W-1:0];
         mul_fix.ovf   = !((&prod_adj[63:DATA_W-1]) || !(|prod_adj[63:DATA_W-1]));
      end
   end

   // Last stage: merge the quotient.
   always_comb begin
      fin = side_ff[NQ-1];
      if (fin.is_div && !fin.dbz) begin
         fin.value = fin.q_neg ? (~quotient[DATA_W-1:0] + 1'b1) : quotient[DATA_W-1:0];
         fin.ovf   = fin.q_neg ?
                     ((|quotient[NQ-1:DATA_W]) ||
                      (quotient[DATA_W-1] && (|quotient[DATA_W-2:0]))) :
                     (|quotient[NQ-1:DATA_W-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NQ; i++) begin
            valid_ff[i] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= item_valid;
         for (int i = 1; i < NQ; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
         out_valid_ff <= valid_ff[NQ-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff    <= prod_in;
         side_ff[0] <= side_in;
         side_ff[1] <= mul_fix;
         for (int i = 2; i < NQ; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         out_ff <= fin;
      end
   end

   assign rsp_result_value   = out_ff.value;
   assign rsp_a_less         = out_ff.lt;
   assign rsp_a_greater      = out_ff.gt;
   assign rsp_a_equal        = out_ff.eq;
   assign rsp_overflow       = out_ff.ovf;
   assign rsp_divide_by_zero = out_ff.dbz;

   `ASSERT_ALWAYS(a_dbz_zero, clock, reset, out_valid_ff && rsp_divide_by_zero |-> rsp_result_value == '0 && !rsp_overflow, "divide by zero gave a value")
   `ASSERT_ALWAYS(a_cmp_onehot, clock, reset, out_valid_ff |-> $onehot({rsp_a_less, rsp_a_greater, rsp_a_equal}), "comparison flags not one-hot")

endmodule
